>>> hdl/ppsr_pkg.sv
//------------------------------------------------------------------------------
// ppsr_pkg
// Types and constants shared by the proxy segment reassembler modules.
//------------------------------------------------------------------------------
`default_nettype none

package ppsr_pkg;

	// largest message that one completion streams out
	localparam int MAX_OUT = 64;

	// sar codes from the segment header
	localparam logic [1:0] SAR_WHOLE = 2'd0;
	localparam logic [1:0] SAR_START = 2'd1;
	localparam logic [1:0] SAR_MID   = 2'd2;
	localparam logic [1:0] SAR_CLOSE = 2'd3;

	// reported status codes
	localparam logic [2:0] STS_OK               = 3'd0;
	localparam logic [2:0] STS_DONE             = 3'd1;
	localparam logic [2:0] STS_COMPLETE_PENDING = 3'd2;
	localparam logic [2:0] STS_FIRST_PENDING    = 3'd3;
	localparam logic [2:0] STS_CONT_EMPTY       = 3'd4;
	localparam logic [2:0] STS_LAST_EMPTY       = 3'd5;
	localparam logic [2:0] STS_MISMATCH         = 3'd6;
	localparam logic [2:0] STS_OVERFLOW         = 3'd7;

	// input word
	typedef struct packed {
		logic [7:0] seg_byte;
		logic       seg_end;
	} seg_word_t;

	// result word
	typedef struct packed {
		logic [2:0] status;
		logic [5:0] msg_kind;
		logic [7:0] data_byte;
		logic       data_valid;
		logic [5:0] byte_index;
		logic       last;
	} res_word_t;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic rd_en;
		logic emit;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic stream_start;
		logic idx_last;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

>>> hdl/ppsr_ctrl.sv
//------------------------------------------------------------------------------
// ppsr_ctrl
// Sequencer: takes input words, then walks the message store on completion.
//------------------------------------------------------------------------------
`default_nettype none

module ppsr_ctrl
	import ppsr_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      seg_valid,
	output logic           seg_ready,
	input  wire dp_stat_t  stat,
	output ctrl_cmd_t      cmd
);

	state_t state_q;
	state_t state_n;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (seg_valid && stat.out_free && stat.stream_start) state_n = S_READ;
			end
			S_READ: begin
				state_n = S_EMIT;
			end
			S_EMIT: begin
				if (stat.out_free) state_n = stat.idx_last ? S_IDLE : S_READ;
			end
			default: state_n = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		seg_ready = 1'b0;
		cmd       = '0;
		unique case (state_q)
			S_IDLE: begin
				seg_ready = stat.out_free;
				cmd.take  = seg_valid && stat.out_free;
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
			end
			S_EMIT: begin
				cmd.emit = stat.out_free;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

>>> hdl/ppsr_datapath.sv
//------------------------------------------------------------------------------
// ppsr_datapath
// Header checks, message store, length and type registers, result register.
//------------------------------------------------------------------------------
`default_nettype none

module ppsr_datapath
	import ppsr_pkg::*;
#(
	parameter int BUFFER_DEPTH = 64
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire seg_word_t seg,
	input  wire ctrl_cmd_t cmd,
	output dp_stat_t       stat,
	output res_word_t      res,
	output logic           res_valid,
	input  wire logic      res_ready
);

	localparam int CAP = (BUFFER_DEPTH < MAX_OUT) ? BUFFER_DEPTH : MAX_OUT;
	localparam int AW  = $clog2(CAP);
	localparam int LW  = $clog2(CAP + 1);

	logic [7:0]    mem [CAP];
	logic [LW-1:0] len_q;
	logic [5:0]    kind_q;
	logic          expect_hdr_q;
	logic [1:0]    sar_q;
	logic [2:0]    sts_q;
	logic [LW-1:0] stream_len_q;
	logic [AW-1:0] rd_idx_q;
	logic [7:0]    rd_data_q;
	logic          res_valid_q;
	res_word_t     res_q;

	logic [1:0]    hdr_sar;
	logic [5:0]    hdr_kind;
	logic [1:0]    sar_n;
	logic [2:0]    sts_n;
	logic [5:0]    kind_n;
	logic [LW-1:0] len_upd;
	logic [LW-1:0] len_n;
	logic          wr_en;
	logic          completes;
	logic          out_free;
	logic          load_single;

	assign hdr_sar  = seg.seg_byte[7:6];
	assign hdr_kind = seg.seg_byte[5:0];

	// per-word segment processing
	always_comb begin
		sar_n   = sar_q;
		sts_n   = sts_q;
		kind_n  = kind_q;
		len_upd = len_q;
		wr_en   = 1'b0;
		if (expect_hdr_q) begin
			sar_n = hdr_sar;
			unique case (hdr_sar)
				SAR_WHOLE, SAR_START: begin
					if (len_q != '0) begin
						sts_n = (hdr_sar == SAR_WHOLE) ? STS_COMPLETE_PENDING
						                               : STS_FIRST_PENDING;
					end else begin
						sts_n  = STS_OK;
						kind_n = hdr_kind;
					end
				end
				default: begin
					if (len_q == '0) begin
						sts_n = (hdr_sar == SAR_MID) ? STS_CONT_EMPTY : STS_LAST_EMPTY;
					end else if (hdr_kind != kind_q) begin
						sts_n = STS_MISMATCH;
					end else begin
						sts_n = STS_OK;
					end
				end
			endcase
		end else if (sts_q == STS_OK) begin
			if (len_q < LW'(CAP)) begin
				wr_en   = 1'b1;
				len_upd = len_q + LW'(1);
			end else begin
				sts_n   = STS_OVERFLOW;
				len_upd = '0;
			end
		end
		completes = seg.seg_end && (sts_n == STS_OK)
		            && ((sar_n == SAR_WHOLE) || (sar_n == SAR_CLOSE));
		len_n = completes ? '0 : len_upd;
	end

	assign out_free          = !res_valid_q || res_ready;
	assign load_single       = cmd.take && seg.seg_end && !(completes && (len_upd != '0));
	assign stat.stream_start = seg.seg_end && completes && (len_upd != '0);
	assign stat.idx_last     = (LW'(rd_idx_q) + LW'(1)) == stream_len_q;
	assign stat.out_free     = out_free;

	// segment state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q        <= '0;
			kind_q       <= '0;
			expect_hdr_q <= 1'b1;
			sar_q        <= SAR_WHOLE;
			sts_q        <= STS_OK;
		end else if (cmd.take) begin
			len_q        <= len_n;
			kind_q       <= kind_n;
			expect_hdr_q <= seg.seg_end;
			sar_q        <= sar_n;
			sts_q        <= sts_n;
		end
	end

	// stream length and read pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_len_q <= '0;
			rd_idx_q     <= '0;
		end else if (cmd.take && stat.stream_start) begin
			stream_len_q <= len_upd;
			rd_idx_q     <= '0;
		end else if (cmd.emit) begin
			rd_idx_q     <= rd_idx_q + AW'(1);
		end
	end

	// message store
	always_ff @(posedge clk) begin
		if (cmd.take && wr_en) mem[len_q[AW-1:0]] <= seg.seg_byte;
		if (cmd.rd_en) rd_data_q <= mem[rd_idx_q];
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_single || cmd.emit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load_single) begin
			res_q.status     <= completes ? STS_DONE : sts_n;
			res_q.msg_kind   <= kind_n;
			res_q.data_byte  <= '0;
			res_q.data_valid <= 1'b0;
			res_q.byte_index <= '0;
			res_q.last       <= 1'b1;
		end else if (cmd.emit) begin
			res_q.status     <= STS_DONE;
			res_q.msg_kind   <= kind_q;
			res_q.data_byte  <= rd_data_q;
			res_q.data_valid <= 1'b1;
			res_q.byte_index <= 6'(rd_idx_q);
			res_q.last       <= stat.idx_last;
		end
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

endmodule

`default_nettype wire

>>> hdl/proxy_pdu_sar_reassembler.sv
// result path: a status word can be taken in the cycle after the segment's last word is
// accepted; a completed message's first byte follows a store read and then a result load
// throughput: one word per cycle while segments are collected and results drain; a
// completed message streams its bytes by alternating store read and result load
// and holds off input until its last byte is loaded
// reset: arst_n clears length, type, sar state and handshake flags; the store is not cleared
//------------------------------------------------------------------------------
// proxy_pdu_sar_reassembler
// Reassembles proxy segments into messages, reports a status per segment.
//------------------------------------------------------------------------------
`default_nettype none

module proxy_pdu_sar_reassembler
	import ppsr_pkg::*;
#(
	parameter int BUFFER_DEPTH = 64
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      seg_valid,
	output logic           seg_ready,
	input  wire seg_word_t seg,
	output logic           res_valid,
	input  wire logic      res_ready,
	output res_word_t      res
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// sequencer
	ppsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg_valid (seg_valid),
		.seg_ready (seg_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath
	ppsr_datapath #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg       (seg),
		.cmd       (cmd),
		.stat      (stat),
		.res       (res),
		.res_valid (res_valid),
		.res_ready (res_ready)
	);

endmodule

`default_nettype wire

>>> hdl/ppsr_checker.sv
//------------------------------------------------------------------------------
// ppsr_props
// Port-level checks on the reassembler, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none

module ppsr_props
	import ppsr_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      seg_ready,
	input wire logic      res_valid,
	input wire logic      res_ready,
	input wire res_word_t res
);

	// a stalled result word holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result word changed while stalled");

	// a status-only word always closes its segment
	a_nodata_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.data_valid |-> res.last && res.data_byte == 8'd0
		&& res.byte_index == 6'd0)
		else $error("status word malformed");

	// message bytes only come with a completion status
	a_data_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.data_valid |-> res.status == STS_DONE)
		else $error("data byte without completion status");

	// no input is taken in the middle of a message stream
	a_stream_block: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.data_valid && !res.last |-> !seg_ready)
		else $error("input taken during message stream");

	// message bytes come out in order
	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && res.data_valid && !res.last ##2
		res_valid && res.data_valid |-> res.byte_index == $past(res.byte_index, 2) + 6'd1)
		else $error("byte index out of order");

endmodule

bind proxy_pdu_sar_reassembler ppsr_props u_ppsr_props (.*);

`default_nettype wire
